// File: rtl/quad_region_point_filter_unit_macros.svh
// Assertion macros for the quad region point filter.
`ifndef QUAD_REGION_POINT_FILTER_UNIT_MACROS_SVH
`define QUAD_REGION_POINT_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define QRPF_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qrpf assertion failed");

// next-cycle implication
`define QRPF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qrpf assertion failed");

`endif

// File: rtl/qrpf_pkg.sv
// Package: types and constants for the quad region point filter.
package qrpf_pkg;

   localparam int VW   = 40;
   localparam int DW   = 41;
   localparam int LOW  = 20;
   localparam int HIW  = DW - LOW;
   localparam int PW   = 2 * DW;
   localparam int TW   = 34;
   localparam int NUMW = 50;
   localparam int CNTW = 6;

   localparam logic signed [VW-1:0] VX_FAR  = 40'sd1572864;
   localparam logic signed [VW-1:0] VX_NEAR = -40'sd262144;
   localparam logic signed [VW-1:0] VY_TOP  = 40'sd2621440;
   localparam logic signed [VW-1:0] VY_BOT  = -40'sd2621440;
   localparam logic signed [TW-1:0] T_POS   = 34'sd1310720;
   localparam logic signed [TW-1:0] T_NEG   = -34'sd1310720;
   localparam logic signed [31:0]   ONE_Q16 = 32'sd65536;

   localparam logic [2:0] CSR_ENABLE      = 3'd0;
   localparam logic [2:0] CSR_SLOPE_A     = 3'd1;
   localparam logic [2:0] CSR_INTERCEPT_A = 3'd2;
   localparam logic [2:0] CSR_SLOPE_B     = 3'd3;
   localparam logic [2:0] CSR_INTERCEPT_B = 3'd4;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [31:0]        point_intensity;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] kept_x;
      logic signed [31:0] kept_y;
      logic signed [31:0] kept_z;
      logic [31:0]        kept_intensity;
   } rsp_payload_type;

   typedef struct packed {
      logic                enable;
      logic                busy;
      logic [3:0][VW-1:0]  vx;
      logic [3:0][VW-1:0]  vy;
      logic [3:0][DW-1:0]  d;
      logic [3:0][DW-1:0]  dx;
   } geom_type;

endpackage

// File: rtl/qrpf_vertex_unit.sv
// Configuration registers and sequential vertex and edge constant builder.
module qrpf_vertex_unit import qrpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output geom_type    geom
);

   typedef enum logic [2:0] {ST_LOAD, ST_RUN, ST_STORE, ST_FIN, ST_IDLE} state_type;

   state_type         state_ff;
   logic [1:0]        job_ff;
   logic [CNTW-1:0]   cnt_ff;
   logic [NUMW-1:0]   num_ff;
   logic [NUMW-1:0]   quo_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       dvsr_ff;
   logic              neg_ff;
   logic [VW-1:0]     qx_ff [4];
   logic              enable_ff;
   logic signed [31:0] slope_a_ff, icpt_a_ff, slope_b_ff, icpt_b_ff;
   logic [3:0][VW-1:0] vx_ff, vy_ff;
   logic [3:0][DW-1:0] d_ff, dx_ff;

   logic signed [31:0]   s_c, c_c;
   logic signed [TW-1:0] t_c;
   logic [TW-2:0]        t_abs_c;
   logic [32:0]          rem_sh_c;
   logic                 ge_c;
   logic [32:0]          rem_sub_c;
   logic [VW-1:0]        qmag_c;
   logic signed [VW-1:0] vx_c [4];
   logic signed [VW-1:0] vy_c [4];
   logic                 sh_a_c, sh_b_c;
   logic signed [VW-1:0] sa_c, ca_c, sb_c, cb_c;

   always_comb begin
      s_c = job_ff[1] ? slope_b_ff : slope_a_ff;
      c_c = job_ff[1] ? icpt_b_ff : icpt_a_ff;
      t_c = ((job_ff == 2'd1) || (job_ff == 2'd2) ? T_POS : T_NEG) - TW'(c_c);
      t_abs_c = t_c[TW-1] ? (TW-1)'(-t_c) : t_c[TW-2:0];
      rem_sh_c = {rem_ff, num_ff[NUMW-1]};
      ge_c = rem_sh_c >= {1'b0, dvsr_ff};
      rem_sub_c = ge_c ? (rem_sh_c - {1'b0, dvsr_ff}) : rem_sh_c;
      qmag_c = quo_ff[VW-1:0] + VW'(neg_ff && (rem_ff != 32'd0));
      sa_c = VW'(slope_a_ff);
      ca_c = VW'(icpt_a_ff);
      sb_c = VW'(slope_b_ff);
      cb_c = VW'(icpt_b_ff);
      sh_a_c = (slope_a_ff > -ONE_Q16) && (slope_a_ff < ONE_Q16);
      sh_b_c = (slope_b_ff > -ONE_Q16) && (slope_b_ff < ONE_Q16);
      if (sh_a_c) begin
         vx_c[0] = VX_FAR;
         vy_c[0] = (sa_c * 12 + ca_c) <<< 1;
         vx_c[1] = VX_NEAR;
         vy_c[1] = sa_c + (ca_c <<< 1);
      end else begin
         vx_c[0] = $signed(qx_ff[0]);
         vy_c[0] = VY_BOT;
         vx_c[1] = $signed(qx_ff[1]);
         vy_c[1] = VY_TOP;
      end
      if (sh_b_c) begin
         vx_c[2] = VX_NEAR;
         vy_c[2] = sb_c + (cb_c <<< 1);
         vx_c[3] = VX_FAR;
         vy_c[3] = (sb_c * 12 + cb_c) <<< 1;
      end else begin
         vx_c[2] = $signed(qx_ff[2]);
         vy_c[2] = VY_TOP;
         vx_c[3] = $signed(qx_ff[3]);
         vy_c[3] = VY_BOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         job_ff     <= 2'd0;
         enable_ff  <= 1'b0;
         slope_a_ff <= '0;
         icpt_a_ff  <= '0;
         slope_b_ff <= '0;
         icpt_b_ff  <= '0;
      end else if (csr_we) begin
         state_ff <= ST_LOAD;
         job_ff   <= 2'd0;
         unique case (csr_index)
            CSR_ENABLE:      enable_ff  <= csr_wdata[0];
            CSR_SLOPE_A:     slope_a_ff <= csr_wdata;
            CSR_INTERCEPT_A: icpt_a_ff  <= csr_wdata;
            CSR_SLOPE_B:     slope_b_ff <= csr_wdata;
            CSR_INTERCEPT_B: icpt_b_ff  <= csr_wdata;
            default: ;
         endcase
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               num_ff   <= {t_abs_c, 17'b0};
               dvsr_ff  <= s_c[31] ? 32'(-s_c) : s_c;
               neg_ff   <= t_c[TW-1] ^ s_c[31];
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= CNTW'(NUMW - 1);
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               rem_ff <= rem_sub_c[31:0];
               num_ff <= {num_ff[NUMW-2:0], 1'b0};
               quo_ff <= {quo_ff[NUMW-2:0], ge_c};
               cnt_ff <= cnt_ff - CNTW'(1);
               if (cnt_ff == '0) state_ff <= ST_STORE;
            end
            ST_STORE: begin
               qx_ff[job_ff] <= neg_ff ? -qmag_c : qmag_c;
               job_ff <= job_ff + 2'd1;
               state_ff <= (job_ff == 2'd3) ? ST_FIN : ST_LOAD;
            end
            ST_FIN: begin
               for (int i = 0; i < 4; i++) begin
                  vx_ff[i] <= vx_c[i];
                  vy_ff[i] <= vy_c[i];
                  d_ff[i]  <= DW'(vy_c[(i + 1) % 4]) - DW'(vy_c[i]);
                  dx_ff[i] <= DW'(vx_c[(i + 1) % 4]) - DW'(vx_c[i]);
               end
               state_ff <= ST_IDLE;
            end
            ST_IDLE: ;
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign geom.enable = enable_ff;
   assign geom.busy   = (state_ff != ST_IDLE);
   assign geom.vx     = vx_ff;
   assign geom.vy     = vy_ff;
   assign geom.d      = d_ff;
   assign geom.dx     = dx_ff;

endmodule

// File: rtl/qrpf_edge_pipe.sv
// Three-stage ray-casting pipeline: offsets, partial products, cross products.
module qrpf_edge_pipe import qrpf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  req_payload_type in_payload,
   input  geom_type        geom,
   output logic            out_valid,
   output req_payload_type out_payload
);

   logic            v1_ff, v2_ff, v3_ff;
   req_payload_type pay1_ff, pay2_ff, pay3_ff;
   logic [3:0]      cross1_ff, cross2_ff, cross3_ff;
   logic [DW-1:0]   a1_ff [4];
   logic [DW-1:0]   b1_ff [4];
   logic [DW+LOW:0] llo2_ff [4];
   logic [DW+LOW:0] rlo2_ff [4];
   logic [DW+HIW-1:0] lhi2_ff [4];
   logic [DW+HIW-1:0] rhi2_ff [4];
   logic [PW-1:0]   l3_ff [4];
   logic [PW-1:0]   r3_ff [4];

   logic signed [DW-1:0] px_c, py_c;
   logic [3:0]           left_c;

   always_comb begin
      px_c = {{(DW-33){in_payload.point_x[31]}}, in_payload.point_x, 1'b0};
      py_c = {{(DW-33){in_payload.point_y[31]}}, in_payload.point_y, 1'b0};
      for (int i = 0; i < 4; i++) begin
         left_c[i] = $signed(geom.d[i]) > 0 ?
                     ($signed(l3_ff[i]) < $signed(r3_ff[i])) :
                     ($signed(r3_ff[i]) < $signed(l3_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pay1_ff <= in_payload;
         for (int i = 0; i < 4; i++) begin
            cross1_ff[i] <= ($signed(DW'($signed(geom.vy[i]))) > py_c) !=
                            ($signed(DW'($signed(geom.vy[(i + 1) % 4]))) > py_c);
            a1_ff[i] <= px_c - DW'($signed(geom.vx[i]));
            b1_ff[i] <= py_c - DW'($signed(geom.vy[i]));
         end
         pay2_ff   <= pay1_ff;
         cross2_ff <= cross1_ff;
         for (int i = 0; i < 4; i++) begin
            llo2_ff[i] <= $signed(a1_ff[i]) * $signed({1'b0, geom.d[i][LOW-1:0]});
            lhi2_ff[i] <= $signed(a1_ff[i]) * $signed(geom.d[i][DW-1:LOW]);
            rlo2_ff[i] <= $signed(geom.dx[i]) * $signed({1'b0, b1_ff[i][LOW-1:0]});
            rhi2_ff[i] <= $signed(geom.dx[i]) * $signed(b1_ff[i][DW-1:LOW]);
         end
         pay3_ff   <= pay2_ff;
         cross3_ff <= cross2_ff;
         for (int i = 0; i < 4; i++) begin
            l3_ff[i] <= (PW'($signed(lhi2_ff[i])) <<< LOW) + PW'($signed(llo2_ff[i]));
            r3_ff[i] <= (PW'($signed(rhi2_ff[i])) <<< LOW) + PW'($signed(rlo2_ff[i]));
         end
      end
   end

   assign out_valid   = v3_ff && (!geom.enable || (^(cross3_ff & left_c)));
   assign out_payload = pay3_ff;

endmodule

// File: rtl/quad_region_point_filter_unit.sv
// Top level: quad region point filter with output register and checks.
// Streams one point per cycle, when the response side is not stalled and the
// vertex unit is not busy, through a four-stage path (three pipeline stages and
// the output register). Points outside the quadrilateral are dropped when the
// filter is enabled. After reset and after every configuration write, req_ready
// stays low while a serial divider rebuilds the four vertices (four 50-step
// divisions plus setup).
`include "quad_region_point_filter_unit_macros.svh"
module quad_region_point_filter_unit import qrpf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_wdata
);

   geom_type        geom;
   logic            advance;
   logic            pipe_valid;
   req_payload_type pipe_payload;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !geom.busy;

   qrpf_vertex_unit u_vertex (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   qrpf_edge_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid && req_ready),
      .in_payload  (req_payload),
      .geom        (geom),
      .out_valid   (pipe_valid),
      .out_payload (pipe_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.kept_x         <= pipe_payload.point_x;
         rsp_payload_ff.kept_y         <= pipe_payload.point_y;
         rsp_payload_ff.kept_z         <= pipe_payload.point_z;
         rsp_payload_ff.kept_intensity <= pipe_payload.point_intensity;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `QRPF_ASSERT_IMPLY(a_busy_blocks_req, geom.busy, !req_ready)
   `QRPF_ASSERT_NEXT(a_csr_write_busy, csr_we, geom.busy)
   `QRPF_ASSERT_IMPLY(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)

endmodule
